// File: src/pts_pkg.sv
// Shared constants, types and controller/datapath interface structs of the task scheduler.
`default_nettype none
package pts_pkg;

    localparam int MAX_TASKS_DEF = 32;

    localparam int TAG_W   = 8;
    localparam int PRI_W   = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 22;
    localparam int TOTAL_W = 27;
    localparam int SCNT_W  = 6;
    localparam int ENTRY_W = TAG_W + PRI_W + BURST_W;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_RUN = 1'b1;

    typedef struct packed {
        logic add_task;
        logic clear_flag;
        logic run_start;
        logic scan_step;
        logic emit;
        logic finish;
    } pts_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_last;
    } pts_status_t;

endpackage
`default_nettype wire

// File: src/pts_datapath.sv
// Task table, priority search, timing accumulators and result register of the scheduler.
`default_nettype none
module pts_datapath import pts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pts_cmd_t             cmd,
    output pts_status_t               status,
    input  wire logic [TAG_W-1:0]     in_tag,
    input  wire logic [PRI_W-1:0]     in_priority,
    input  wire logic [BURST_W-1:0]   in_burst,
    output logic [TAG_W-1:0]          out_tag,
    output logic [PRI_W-1:0]          out_priority,
    output logic [BURST_W-1:0]        out_burst,
    output logic [TIME_W-1:0]         wait_time,
    output logic [TIME_W-1:0]         turnaround_time,
    output logic [TOTAL_W-1:0]        total_wait,
    output logic [TOTAL_W-1:0]        total_turnaround,
    output logic [SCNT_W-1:0]         served_count,
    output logic                      overflow_seen,
    output logic                      last
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [ENTRY_W-1:0]   mem [MAX_TASKS];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic                 rd_vld_reg;

    logic [CW-1:0]        count_reg;
    logic                 dropped_reg;
    logic [CW-1:0]        scan_idx_reg;
    logic [CW-1:0]        done_reg;
    logic [MAX_TASKS-1:0] served_reg;

    logic                 best_found_reg;
    logic [IW-1:0]        best_idx_reg;
    logic [ENTRY_W-1:0]   best_data_reg;

    logic [TIME_W-1:0]    elapsed_reg;
    logic [TOTAL_W-1:0]   tot_w_reg;
    logic [TOTAL_W-1:0]   tot_t_reg;

    logic [TAG_W-1:0]     out_tag_reg;
    logic [PRI_W-1:0]     out_priority_reg;
    logic [BURST_W-1:0]   out_burst_reg;
    logic [TIME_W-1:0]    wait_time_reg;
    logic [TIME_W-1:0]    turnaround_time_reg;
    logic [TOTAL_W-1:0]   total_wait_reg;
    logic [TOTAL_W-1:0]   total_turnaround_reg;
    logic [SCNT_W-1:0]    served_count_reg;
    logic                 overflow_seen_reg;
    logic                 last_reg;

    logic                 table_full;
    logic                 take;
    logic [TIME_W:0]      turn_sum;
    logic [TIME_W-1:0]    turn_next;
    logic [TOTAL_W:0]     tot_w_sum;
    logic [TOTAL_W:0]     tot_t_sum;
    logic [TOTAL_W-1:0]   tot_w_next;
    logic [TOTAL_W-1:0]   tot_t_next;
    logic [6:0]           count_ext;
    logic [SCNT_W-1:0]    count_sat;
    logic                 emit_last;

    assign table_full = (count_reg == CW'(MAX_TASKS));
    assign take = rd_vld_reg && !served_reg[rd_idx_reg] &&
                  (!best_found_reg ||
                   (rd_data_reg[BURST_W +: PRI_W] > best_data_reg[BURST_W +: PRI_W]));

    assign turn_sum   = {1'b0, elapsed_reg} + (TIME_W+1)'(best_data_reg[BURST_W-1:0]);
    assign turn_next  = turn_sum[TIME_W] ? {TIME_W{1'b1}} : turn_sum[TIME_W-1:0];
    assign tot_w_sum  = {1'b0, tot_w_reg} + (TOTAL_W+1)'(elapsed_reg);
    assign tot_t_sum  = {1'b0, tot_t_reg} + (TOTAL_W+1)'(turn_next);
    assign tot_w_next = tot_w_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_w_sum[TOTAL_W-1:0];
    assign tot_t_next = tot_t_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_t_sum[TOTAL_W-1:0];
    assign count_ext  = 7'(count_reg);
    assign count_sat  = (count_ext > 7'd63) ? 6'd63 : count_ext[SCNT_W-1:0];
    assign emit_last  = ((done_reg + CW'(1)) == count_reg);

    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = ((scan_idx_reg + CW'(1)) == count_reg);
    assign status.out_last   = last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.add_task && !table_full) begin
            mem[count_reg[IW-1:0]] <= {in_tag, in_priority, in_burst};
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[scan_idx_reg[IW-1:0]];
        rd_idx_reg  <= scan_idx_reg[IW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            dropped_reg    <= 1'b0;
            rd_vld_reg     <= 1'b0;
            scan_idx_reg   <= '0;
            done_reg       <= '0;
            served_reg     <= '0;
            best_found_reg <= 1'b0;
            elapsed_reg    <= '0;
            tot_w_reg      <= '0;
            tot_t_reg      <= '0;
            last_reg       <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_step;
            if (cmd.add_task) begin
                if (table_full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.clear_flag || cmd.finish) begin
                dropped_reg <= 1'b0;
            end
            if (cmd.finish) begin
                count_reg <= '0;
            end
            if (cmd.run_start) begin
                scan_idx_reg   <= '0;
                done_reg       <= '0;
                served_reg     <= '0;
                best_found_reg <= 1'b0;
                elapsed_reg    <= '0;
                tot_w_reg      <= '0;
                tot_t_reg      <= '0;
            end
            if (cmd.scan_step) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (take) begin
                best_found_reg <= 1'b1;
            end
            if (cmd.emit) begin
                served_reg[best_idx_reg] <= 1'b1;
                scan_idx_reg   <= '0;
                best_found_reg <= 1'b0;
                done_reg       <= done_reg + CW'(1);
                elapsed_reg    <= turn_next;
                tot_w_reg      <= tot_w_next;
                tot_t_reg      <= tot_t_next;
                last_reg       <= emit_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg  <= rd_idx_reg;
            best_data_reg <= rd_data_reg;
        end
        if (cmd.emit) begin
            out_tag_reg          <= best_data_reg[BURST_W+PRI_W +: TAG_W];
            out_priority_reg     <= best_data_reg[BURST_W +: PRI_W];
            out_burst_reg        <= best_data_reg[BURST_W-1:0];
            wait_time_reg        <= elapsed_reg;
            turnaround_time_reg  <= turn_next;
            total_wait_reg       <= emit_last ? tot_w_next : '0;
            total_turnaround_reg <= emit_last ? tot_t_next : '0;
            served_count_reg     <= emit_last ? count_sat : '0;
            overflow_seen_reg    <= dropped_reg;
        end
    end

    assign out_tag          = out_tag_reg;
    assign out_priority     = out_priority_reg;
    assign out_burst        = out_burst_reg;
    assign wait_time        = wait_time_reg;
    assign turnaround_time  = turnaround_time_reg;
    assign total_wait       = total_wait_reg;
    assign total_turnaround = total_turnaround_reg;
    assign served_count     = served_count_reg;
    assign overflow_seen    = overflow_seen_reg;
    assign last             = last_reg;

endmodule
`default_nettype wire

// File: src/pts_ctrl.sv
// Controller state machine sequencing adds, table scans and result handoff.
`default_nettype none
module pts_ctrl import pts_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        req_type,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire pts_status_t status,
    output pts_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_HOLD
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (req_type == REQ_ADD) begin
                        cmd.add_task = 1'b1;
                    end else if (status.count_zero) begin
                        cmd.clear_flag = 1'b1;
                    end else begin
                        cmd.run_start = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit   = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_ready) begin
                    if (status.out_last) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        s_ready_next = (state_next == ST_IDLE);
        m_valid_next = (state_next == ST_HOLD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// File: src/priority_task_scheduler_unit.sv
// An add transaction is accepted directly in the idle state; a run on n stored tasks yields n results.
// Each result needs a full table scan through the single memory read port, a drain state
// for the last read, an emit state to load the result register, then the output handshake.
// One item is handled at a time.
// Reset (aresetn low, synchronous) empties the table and clears the drop flag; no clearing pass.
// Top level of the priority task scheduler: controller, datapath and assertions.
`default_nettype none
module priority_task_scheduler_unit import pts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire logic [TAG_W-1:0]   s_task_tag,
    input  wire logic [PRI_W-1:0]   s_task_priority,
    input  wire logic [BURST_W-1:0] s_task_burst,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [TAG_W-1:0]        m_out_tag,
    output logic [PRI_W-1:0]        m_out_priority,
    output logic [BURST_W-1:0]      m_out_burst,
    output logic [TIME_W-1:0]       m_wait_time,
    output logic [TIME_W-1:0]       m_turnaround_time,
    output logic [TOTAL_W-1:0]      m_total_wait,
    output logic [TOTAL_W-1:0]      m_total_turnaround,
    output logic [SCNT_W-1:0]       m_served_count,
    output logic                    m_overflow_seen,
    output logic                    m_last
);

    pts_cmd_t    cmd;
    pts_status_t status;

    pts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_req_type),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .in_tag           (s_task_tag),
        .in_priority      (s_task_priority),
        .in_burst         (s_task_burst),
        .out_tag          (m_out_tag),
        .out_priority     (m_out_priority),
        .out_burst        (m_out_burst),
        .wait_time        (m_wait_time),
        .turnaround_time  (m_turnaround_time),
        .total_wait       (m_total_wait),
        .total_turnaround (m_total_turnaround),
        .served_count     (m_served_count),
        .overflow_seen    (m_overflow_seen),
        .last             (m_last)
    );

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_valid && s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready && !m_valid)
        else $error("block not idle after final result of a run");

    a_totals_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_served_count == '0 && m_total_wait == '0)
        else $error("run totals shown before the final result");

    a_turnaround_ge_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_turnaround_time >= m_wait_time)
        else $error("turnaround below waiting time");
`endif

endmodule
`default_nettype wire
